### rtl/tlg_pkg.sv
// Shared types and constants of the toroidal life grid engine.
// Used by tlg_life_rule and the top level; depends on nothing.
package tlg_pkg;

    localparam int GRID_DIM_DEF  = 32;
    localparam int COORD_W       = 5;
    localparam int COORD_SPAN    = 1 << COORD_W;
    localparam int CMD_W         = 3;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STEP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POLL   = 3'd5;

    // B3/S23 neighbor counts
    localparam int LIFE_BIRTH   = 3;
    localparam int LIFE_SURVIVE = 2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               cell_value;
    } req_item_t;

    typedef struct packed {
        logic alive;
        logic was_alive;
        logic just_activated;
        logic just_deactivated;
        logic updated_flag;
    } rsp_item_t;

endpackage

### rtl/tlg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependencies.
module tlg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/tlg_life_rule.sv
// Next-generation rule for one grid row, columns wrap around.
// Uses tlg_pkg for the birth and survival counts.
module tlg_life_rule #(
    parameter int N = tlg_pkg::GRID_DIM_DEF
) (
    input  logic [N-1:0] up,
    input  logic [N-1:0] mid,
    input  logic [N-1:0] dn,
    output logic [N-1:0] nxt
);

    for (genvar c = 0; c < N; c++)
    begin : g_cell
        localparam int LF = (c == 0) ? N - 1 : c - 1;
        localparam int RT = (c == N - 1) ? 0 : c + 1;
        logic [3:0] cnt;

        assign cnt = 4'(up[LF]) + 4'(up[c]) + 4'(up[RT])
                   + 4'(mid[LF]) + 4'(mid[RT])
                   + 4'(dn[LF]) + 4'(dn[c]) + 4'(dn[RT]);

        assign nxt[c] = (cnt == 4'(tlg_pkg::LIFE_BIRTH))
                     || (mid[c] && (cnt == 4'(tlg_pkg::LIFE_SURVIVE)));
    end

endmodule

### rtl/toroidal_life_grid_engine.sv
// Top level of the toroidal life grid engine: command sequencer, row valid bits,
// current/previous grid RAMs. Depends on tlg_pkg, tlg_ram, tlg_life_rule.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------
//  req     | in  | req_valid, req_stall | tlg_pkg::req_item_t
//  rsp     | out | rsp_valid, rsp_stall | tlg_pkg::rsp_item_t
//
// One item at a time. Clear, poll and unused codes go to S_DONE; set, toggle and
// query pass through S_ACCESS (row read through the RAM read latency); step runs
// the row walk, which reads one row of the current grid per cycle and writes one
// row of both grids per cycle. Reset and clear invalidate the per-row valid bits,
// so no clearing pass is needed. A result waiting in the output register does not
// block acceptance; only finishing the next item waits for the slot.
module toroidal_life_grid_engine #(
    parameter int GRID_DIM = tlg_pkg::GRID_DIM_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  tlg_pkg::req_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output tlg_pkg::rsp_item_t  rsp
);

    localparam int RW   = $clog2(GRID_DIM);
    localparam int TW   = $clog2(GRID_DIM + 3);
    localparam int SPAN = tlg_pkg::COORD_SPAN;

    localparam logic [TW-1:0] T_ROW0     = TW'(2);
    localparam logic [TW-1:0] T_FIRST_WR = TW'(3);
    localparam logic [TW-1:0] T_LAST_RD  = TW'(GRID_DIM);
    localparam logic [TW-1:0] T_LAST     = TW'(GRID_DIM + 2);

    // coordinate reduction table, built at elaboration
    function automatic logic [SPAN*RW-1:0] build_wrap();
        logic [SPAN*RW-1:0] lut;
        lut = '0;
        for (int i = 0; i < SPAN; i++)
        begin
            lut[i*RW +: RW] = RW'(i % GRID_DIM);
        end
        return lut;
    endfunction

    localparam logic [SPAN*RW-1:0] WRAP_LUT = build_wrap();

    typedef enum logic [1:0] {S_IDLE, S_ACCESS, S_STEP, S_DONE} state_t;

    state_t                 state_reg;
    logic [TW-1:0]          t_reg;
    logic [GRID_DIM-1:0]    cur_valid_reg;
    logic [GRID_DIM-1:0]    prev_valid_reg;
    logic                   cur_ok_reg;
    logic                   prev_ok_reg;
    logic                   changed_flag_reg;
    logic                   rsp_valid_reg;
    tlg_pkg::rsp_item_t     rsp_reg;
    tlg_pkg::rsp_item_t     rsp_next;

    tlg_pkg::req_item_t     item_reg;
    logic [RW-1:0]          row_reg;
    logic [RW-1:0]          col_reg;
    tlg_pkg::rsp_item_t     res_reg;
    logic [GRID_DIM-1:0]    a_reg;
    logic [GRID_DIM-1:0]    b_reg;
    logic [GRID_DIM-1:0]    row0_reg;

    logic                   accept;
    logic                   slot_free;
    logic                   done_fire;
    logic [RW-1:0]          req_row_w;
    logic [RW-1:0]          req_col_w;
    logic [TW-1:0]          t_m1;
    logic [TW-1:0]          t_m3;
    logic [RW-1:0]          raddr;
    logic [GRID_DIM-1:0]    cur_rdata;
    logic [GRID_DIM-1:0]    prev_rdata;
    logic [GRID_DIM-1:0]    cur_rd;
    logic [GRID_DIM-1:0]    prev_rd;
    logic [GRID_DIM-1:0]    inc_row;
    logic [GRID_DIM-1:0]    rule_next;
    logic [GRID_DIM-1:0]    cur_edit;
    logic [GRID_DIM-1:0]    prev_edit;
    logic                   new_bit;
    logic                   edit_we;
    logic                   step_we;
    logic                   ram_we;
    logic [RW-1:0]          waddr;
    logic [GRID_DIM-1:0]    cur_wdata;
    logic [GRID_DIM-1:0]    prev_wdata;
    logic                   cmd_sets_flag;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign done_fire = (state_reg == S_DONE) && slot_free;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign req_row_w = WRAP_LUT[RW*req.row +: RW];
    assign req_col_w = WRAP_LUT[RW*req.col +: RW];

    assign t_m1 = t_reg - TW'(1);
    assign t_m3 = t_reg - TW'(3);

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:   raddr = req_row_w;
            S_STEP:   raddr = (t_reg == '0) ? RW'(GRID_DIM - 1) : t_m1[RW-1:0];
            default:  raddr = row_reg;
        endcase
    end

    // rows never written since reset or clear read as dead
    assign cur_rd  = cur_rdata & {GRID_DIM{cur_ok_reg}};
    assign prev_rd = prev_rdata & {GRID_DIM{prev_ok_reg}};

    // the last row's lower neighbor is the old row 0, already overwritten
    assign inc_row = (t_reg == T_LAST) ? row0_reg : cur_rd;

    always_comb
    begin
        new_bit   = (item_reg.cmd == tlg_pkg::CMD_SET) ? item_reg.cell_value
                                                        : ~cur_rd[col_reg];
        cur_edit  = cur_rd;
        prev_edit = prev_rd;
        cur_edit[col_reg]  = new_bit;
        prev_edit[col_reg] = new_bit;
    end

    always_comb
    begin
        rsp_next              = res_reg;
        rsp_next.updated_flag = (item_reg.cmd == tlg_pkg::CMD_POLL) && changed_flag_reg;
    end

    assign edit_we = (state_reg == S_ACCESS)
                  && ((item_reg.cmd == tlg_pkg::CMD_SET) || (item_reg.cmd == tlg_pkg::CMD_TOGGLE));
    assign step_we = (state_reg == S_STEP) && (t_reg >= T_FIRST_WR);
    assign ram_we  = edit_we || step_we;
    assign waddr      = step_we ? t_m3[RW-1:0] : row_reg;
    assign cur_wdata  = step_we ? rule_next : cur_edit;
    assign prev_wdata = step_we ? b_reg : prev_edit;

    assign cmd_sets_flag = (item_reg.cmd == tlg_pkg::CMD_CLEAR)
                        || (item_reg.cmd == tlg_pkg::CMD_SET)
                        || (item_reg.cmd == tlg_pkg::CMD_TOGGLE)
                        || (item_reg.cmd == tlg_pkg::CMD_STEP);

    tlg_ram #(
        .WIDTH (GRID_DIM),
        .DEPTH (GRID_DIM)
    ) u_cur_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (cur_wdata),
        .raddr (raddr),
        .rdata (cur_rdata)
    );

    tlg_ram #(
        .WIDTH (GRID_DIM),
        .DEPTH (GRID_DIM)
    ) u_prev_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (prev_wdata),
        .raddr (raddr),
        .rdata (prev_rdata)
    );

    tlg_life_rule #(
        .N (GRID_DIM)
    ) u_rule (
        .up  (a_reg),
        .mid (b_reg),
        .dn  (inc_row),
        .nxt (rule_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            t_reg            <= '0;
            cur_valid_reg    <= '0;
            prev_valid_reg   <= '0;
            cur_ok_reg       <= 1'b0;
            prev_ok_reg      <= 1'b0;
            changed_flag_reg <= 1'b1;
            rsp_valid_reg    <= 1'b0;
            rsp_reg          <= '0;
        end
        else
        begin
            cur_ok_reg  <= cur_valid_reg[raddr];
            prev_ok_reg <= prev_valid_reg[raddr];

            if (rsp_valid_reg && !rsp_stall && !done_fire)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (ram_we)
            begin
                cur_valid_reg[waddr]  <= 1'b1;
                prev_valid_reg[waddr] <= 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        t_reg <= '0;
                        priority if ((req.cmd == tlg_pkg::CMD_SET)
                                  || (req.cmd == tlg_pkg::CMD_TOGGLE)
                                  || (req.cmd == tlg_pkg::CMD_QUERY))
                        begin
                            state_reg <= S_ACCESS;
                        end
                        else if (req.cmd == tlg_pkg::CMD_STEP)
                        begin
                            state_reg <= S_STEP;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_ACCESS:
                begin
                    state_reg <= S_DONE;
                end
                S_STEP:
                begin
                    t_reg <= t_reg + TW'(1);
                    if (t_reg == T_LAST)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (slot_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_reg       <= rsp_next;
                        if (item_reg.cmd == tlg_pkg::CMD_POLL)
                        begin
                            changed_flag_reg <= 1'b0;
                        end
                        else if (cmd_sets_flag)
                        begin
                            changed_flag_reg <= 1'b1;
                        end
                        if (item_reg.cmd == tlg_pkg::CMD_CLEAR)
                        begin
                            cur_valid_reg  <= '0;
                            prev_valid_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
            row_reg  <= req_row_w;
            col_reg  <= req_col_w;
            res_reg  <= '0;
        end

        if ((state_reg == S_ACCESS) && (item_reg.cmd == tlg_pkg::CMD_QUERY))
        begin
            res_reg.alive            <= cur_rd[col_reg];
            res_reg.was_alive        <= prev_rd[col_reg];
            res_reg.just_activated   <= cur_rd[col_reg] && !prev_rd[col_reg];
            res_reg.just_deactivated <= prev_rd[col_reg] && !cur_rd[col_reg];
        end

        // three-row window slides down one row per cycle of the walk
        if ((state_reg == S_STEP) && (t_reg != '0))
        begin
            a_reg <= b_reg;
            b_reg <= inc_row;
            if (t_reg == T_ROW0)
            begin
                row0_reg <= inc_row;
            end
        end
    end

    a_step_fills_grid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && (item_reg.cmd == tlg_pkg::CMD_STEP))
        |-> ((&cur_valid_reg) && (&prev_valid_reg)))
        else $error("step finished with rows left unwritten");

    a_walk_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (step_we && (t_reg <= T_LAST_RD)) |-> (waddr != raddr))
        else $error("row walk writes the row it is reading");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the finish state");

    a_poll_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (done_fire && (item_reg.cmd == tlg_pkg::CMD_POLL)) |=> !changed_flag_reg)
        else $error("poll left the updated flag set");

endmodule
